### design/conformal_hough_vote_accumulator_macros.svh
// assertion macros shared by the hough vote accumulator modules
`ifndef CONFORMAL_HOUGH_VOTE_ACCUMULATOR_MACROS_SVH
`define CONFORMAL_HOUGH_VOTE_ACCUMULATOR_MACROS_SVH

// consequent checked in the same cycle
`define CHVA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the next cycle
`define CHVA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/chva_pkg.sv
// types and constants of the hough vote accumulator
`default_nettype none

package chva_pkg;

   // payload widths
   localparam int HIT_W      = 20;
   localparam int TRIG_W     = 18;
   localparam int COUNT_W    = 16;
   localparam int USED_W     = 9;
   localparam int RCFG_W     = 32;
   localparam int IDX_W      = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // conformal divider
   localparam int SUMSQ_W   = 40;
   localparam int QUOT_W    = 31;
   localparam int DIV_STEPS = 50;
   localparam int DIV_CNT_W = 6;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_THETA_USED = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_R_USED     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_R_MIN      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_R_MAX      = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_R_INV      = 3'd4;

   // register reset values
   localparam logic [USED_W-1:0] THETA_USED_RST = 9'd256;
   localparam logic [USED_W-1:0] R_USED_RST     = 9'd256;
   localparam logic [RCFG_W-1:0] R_MIN_RST      = 32'h0000_0000;
   localparam logic [RCFG_W-1:0] R_MAX_RST      = 32'h0100_0000;
   localparam logic [RCFG_W-1:0] R_INV_RST      = 32'h0100_0000;

   typedef enum logic [1:0] {
      OP_VOTE  = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_TRIG  = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SQUARE,
      ST_SUM,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_VOTE,
      ST_READ,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic square;
      logic sum;
      logic div_start;
      logic theta_init;
      logic issue;
      logic clear_step;
      logic read_bin;
      logic trig_write;
      logic max_clear;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       zero_radius;
      logic       div_done;
      logic       theta_done;
      logic       clear_last;
      logic       pipe_empty;
   } dp_status_type;

endpackage

`default_nettype wire

### design/chva_if.sv
// channel interfaces of the hough vote accumulator
`default_nettype none

interface chva_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [1:0]                               opcode;
   logic signed [chva_pkg::HIT_W-1:0]        hit_z;
   logic signed [chva_pkg::HIT_W-1:0]        hit_x;
   logic [chva_pkg::IDX_W-1:0]               theta_index;
   logic [chva_pkg::IDX_W-1:0]               r_index;
   logic signed [chva_pkg::TRIG_W-1:0]       cos_value;
   logic signed [chva_pkg::TRIG_W-1:0]       sin_value;

   modport source (output valid, opcode, hit_z, hit_x, theta_index, r_index,
                   cos_value, sin_value, input ready);
   modport sink (input valid, opcode, hit_z, hit_x, theta_index, r_index,
                 cos_value, sin_value, output ready);
endinterface

interface chva_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [chva_pkg::COUNT_W-1:0]  bin_count;
   logic [chva_pkg::COUNT_W-1:0]  vote_max;
   logic                          status;

   modport source (output valid, bin_count, vote_max, status, input ready);
   modport sink (input valid, bin_count, vote_max, status, output ready);
endinterface

interface chva_csr_if;
   logic                             valid;
   logic                             ready;
   logic [chva_pkg::CSR_ADDR_W-1:0]  index;
   logic [chva_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/conformal_hough_vote_accumulator.sv
// vote: conformal divider, then one theta bin a cycle, then a 6 stage drain
// clear: one bin a cycle over all THETA_BINS * R_BINS bins of the store
// one item at a time; the next transfer is taken while the last result waits in its register
// reset: synchronous, active high; registers take reset values, then the bin store is
// swept to zero over all THETA_BINS * R_BINS bins while no transfer is taken
`default_nettype none

module conformal_hough_vote_accumulator #(
   parameter int THETA_BINS = 256,
   parameter int R_BINS     = 256
) (
   input wire logic   clock,
   input wire logic   reset,
   chva_req_if.sink   req_if,
   chva_rsp_if.source rsp_if,
   chva_csr_if.sink   csr_if
);

   chva_pkg::dp_cmd_type    cmd;
   chva_pkg::dp_status_type status;

   // registers always take a write
   assign csr_if.ready = 1'b1;

   chva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .status    (status)
   );

   chva_datapath #(
      .THETA_BINS (THETA_BINS),
      .R_BINS     (R_BINS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_opcode      (req_if.opcode),
      .req_hit_z       (req_if.hit_z),
      .req_hit_x       (req_if.hit_x),
      .req_theta_index (req_if.theta_index),
      .req_r_index     (req_if.r_index),
      .req_cos_value   (req_if.cos_value),
      .req_sin_value   (req_if.sin_value),
      .csr_valid       (csr_if.valid && csr_if.ready),
      .csr_index       (csr_if.index),
      .csr_data        (csr_if.data),
      .rsp_bin_count   (rsp_if.bin_count),
      .rsp_vote_max    (rsp_if.vote_max),
      .rsp_status      (rsp_if.status)
   );

endmodule

`default_nettype wire

### design/chva_div.sv
// restoring divider for the conformal map, one quotient bit per cycle
`default_nettype none

module chva_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [chva_pkg::HIT_W-1:0]        dividend,
   input  wire logic [chva_pkg::SUMSQ_W-1:0]      divisor,
   output logic      [chva_pkg::QUOT_W-1:0]       quotient,
   output logic                                   done
);

   localparam int DVD_W = chva_pkg::DIV_STEPS;

   logic [DVD_W-1:0]                   dvd_ff, dvd_in;
   logic [chva_pkg::SUMSQ_W-1:0]       rem_ff, rem_in;
   logic [chva_pkg::QUOT_W-1:0]        quo_ff, quo_in;
   logic [chva_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [chva_pkg::SUMSQ_W:0]         rem_sh;
   logic                               ge;

   // start load or one shift and subtract step
   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[DVD_W-1]};
      ge      = rem_sh >= {1'b0, divisor};
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         dvd_in  = {dividend, (DVD_W - chva_pkg::HIT_W)'(0)};
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         rem_in = ge ? chva_pkg::SUMSQ_W'(rem_sh - {1'b0, divisor})
                     : rem_sh[chva_pkg::SUMSQ_W-1:0];
         quo_in = {quo_ff[chva_pkg::QUOT_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == chva_pkg::DIV_CNT_W'(chva_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

### design/chva_datapath.sv
// datapath: config registers, conformal map, theta vote pipeline, bin store
`default_nettype none
`include "conformal_hough_vote_accumulator_macros.svh"

module chva_datapath #(
   parameter int THETA_BINS = 256,
   parameter int R_BINS     = 256
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire chva_pkg::dp_cmd_type                  cmd,
   output chva_pkg::dp_status_type                    status,
   input  wire logic [1:0]                            req_opcode,
   input  wire logic signed [chva_pkg::HIT_W-1:0]     req_hit_z,
   input  wire logic signed [chva_pkg::HIT_W-1:0]     req_hit_x,
   input  wire logic [chva_pkg::IDX_W-1:0]            req_theta_index,
   input  wire logic [chva_pkg::IDX_W-1:0]            req_r_index,
   input  wire logic signed [chva_pkg::TRIG_W-1:0]    req_cos_value,
   input  wire logic signed [chva_pkg::TRIG_W-1:0]    req_sin_value,
   input  wire logic                                  csr_valid,
   input  wire logic [chva_pkg::CSR_ADDR_W-1:0]       csr_index,
   input  wire logic [chva_pkg::CSR_DATA_W-1:0]       csr_data,
   output logic [chva_pkg::COUNT_W-1:0]               rsp_bin_count,
   output logic [chva_pkg::COUNT_W-1:0]               rsp_vote_max,
   output logic                                       rsp_status
);

   localparam int TW    = $clog2(THETA_BINS);
   localparam int TCW   = $clog2(THETA_BINS + 1);
   localparam int RIW   = $clog2(R_BINS);
   localparam int RCW   = $clog2(R_BINS + 1);
   localparam int DEPTH = THETA_BINS * R_BINS;
   localparam int AW    = $clog2(DEPTH);
   localparam int HW    = chva_pkg::HIT_W;
   localparam int CW    = chva_pkg::COUNT_W;
   localparam int PW    = 50;
   localparam int IXW   = 25;

   // captured request
   chva_pkg::opcode_type                op_ff;
   logic signed [HW-1:0]                z_ff, x_ff;
   logic [chva_pkg::IDX_W-1:0]          ti_ff, ri_ff;
   logic signed [chva_pkg::TRIG_W-1:0]  cosv_ff, sinv_ff;

   // configuration
   logic [chva_pkg::USED_W-1:0]         theta_used_ff, r_used_ff;
   logic signed [chva_pkg::RCFG_W-1:0]  r_min_ff, r_max_ff;
   logic [chva_pkg::RCFG_W-1:0]         r_inv_ff;

   // conformal map
   logic signed [2*HW-1:0]              sqz, sqx;
   logic [2*HW-1:0]                     sq_z_ff, sq_x_ff;
   logic [chva_pkg::SUMSQ_W-1:0]        sum_sq_ff;
   logic [HW-1:0]                       mag_z, mag_x;
   logic [chva_pkg::QUOT_W-1:0]         quo_z, quo_x;
   logic                                done_z, done_x;
   logic signed [31:0]                  zp_ff, xp_ff;

   // counters
   logic [TCW-1:0]                      theta_cnt_ff, nth;
   logic [RCW-1:0]                      nr, nr_m1;
   logic [AW-1:0]                       clear_addr_ff;
   logic [TW-1:0]                       tidx;

   // memories
   logic signed [chva_pkg::TRIG_W-1:0]  cos_mem [THETA_BINS];
   logic signed [chva_pkg::TRIG_W-1:0]  sin_mem [THETA_BINS];
   logic [CW-1:0]                       store [DEPTH];

   // pipeline
   logic                                v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic signed [chva_pkg::TRIG_W-1:0]  cos_rd_ff, sin_rd_ff;
   logic [AW-1:0]                       base1_ff, base2_ff, base3_ff, base4_ff;
   logic signed [PW-1:0]                pz, px, pz_ff, px_ff;
   logic signed [PW:0]                  psum;
   logic signed [34:0]                  r_val, rmin35, rmax35, r_diff;
   logic                                in_range;
   logic [31:0]                         d3_ff;
   logic [47:0]                         mh_ff, ml_ff;
   logic [48:0]                         acc;
   logic [IXW-1:0]                      idx;
   logic [RIW-1:0]                      idx_sel;
   logic [AW-1:0]                       addr5_ff, addr6_ff, rd_addr, bin_addr;
   logic [CW-1:0]                       rd_ff, inc_count, max_count_ff;
   logic                                rd_ok, ti_ok;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= chva_pkg::opcode_type'(req_opcode);
         z_ff    <= req_hit_z;
         x_ff    <= req_hit_x;
         ti_ff   <= req_theta_index;
         ri_ff   <= req_r_index;
         cosv_ff <= req_cos_value;
         sinv_ff <= req_sin_value;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         theta_used_ff <= chva_pkg::THETA_USED_RST;
         r_used_ff     <= chva_pkg::R_USED_RST;
         r_min_ff      <= chva_pkg::R_MIN_RST;
         r_max_ff      <= chva_pkg::R_MAX_RST;
         r_inv_ff      <= chva_pkg::R_INV_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            chva_pkg::CSR_THETA_USED: theta_used_ff <= csr_data[chva_pkg::USED_W-1:0];
            chva_pkg::CSR_R_USED:     r_used_ff     <= csr_data[chva_pkg::USED_W-1:0];
            chva_pkg::CSR_R_MIN:      r_min_ff      <= csr_data;
            chva_pkg::CSR_R_MAX:      r_max_ff      <= csr_data;
            chva_pkg::CSR_R_INV:      r_inv_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // bin counts in use, saturated to the store size, with at least one r bin
   always_comb begin
      if (32'(theta_used_ff) > THETA_BINS) nth = TCW'(THETA_BINS);
      else nth = TCW'(theta_used_ff);
      if (32'(r_used_ff) > R_BINS) nr = RCW'(R_BINS);
      else if (r_used_ff == '0) nr = RCW'(1);
      else nr = RCW'(r_used_ff);
      nr_m1 = nr - 1'b1;
   end

   // squares then sum of squares
   assign sqz = z_ff * z_ff;
   assign sqx = x_ff * x_ff;
   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sq_z_ff <= sqz;
         sq_x_ff <= sqx;
      end
      if (cmd.sum) sum_sq_ff <= chva_pkg::SUMSQ_W'(sq_z_ff + sq_x_ff);
   end

   assign mag_z = z_ff[HW-1] ? HW'(-z_ff) : z_ff;
   assign mag_x = x_ff[HW-1] ? HW'(-x_ff) : x_ff;

   chva_div u_div_z (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (mag_z),
      .divisor  (sum_sq_ff),
      .quotient (quo_z),
      .done     (done_z)
   );

   chva_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (mag_x),
      .divisor  (sum_sq_ff),
      .quotient (quo_x),
      .done     (done_x)
   );

   // signed conformal coordinates, Q2.30
   always_ff @(posedge clock) begin
      if (cmd.theta_init) begin
         zp_ff <= z_ff[HW-1] ? -$signed({1'b0, quo_z}) : $signed({1'b0, quo_z});
         xp_ff <= x_ff[HW-1] ? -$signed({1'b0, quo_x}) : $signed({1'b0, quo_x});
      end
   end

   // theta issue counter and clear sweep address
   always_ff @(posedge clock) begin
      if (reset) begin
         theta_cnt_ff  <= '0;
         clear_addr_ff <= '0;
      end else begin
         if (cmd.theta_init) theta_cnt_ff <= '0;
         else if (cmd.issue) theta_cnt_ff <= theta_cnt_ff + 1'b1;
         if (cmd.clear_step) begin
            if (clear_addr_ff == AW'(DEPTH - 1)) clear_addr_ff <= '0;
            else clear_addr_ff <= clear_addr_ff + 1'b1;
         end
      end
   end

   assign tidx = theta_cnt_ff[TW-1:0];

   // trig tables
   assign ti_ok = 32'(ti_ff) < THETA_BINS;
   always_ff @(posedge clock) begin
      if (cmd.trig_write && ti_ok) begin
         cos_mem[TW'(ti_ff)] <= cosv_ff;
         sin_mem[TW'(ti_ff)] <= sinv_ff;
      end
   end

   // stage 1: trig read and row base
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         cos_rd_ff <= cos_mem[tidx];
         sin_rd_ff <= sin_mem[tidx];
         base1_ff  <= AW'(32'(tidx) * R_BINS);
      end
   end

   // stage 2: projections
   assign pz = zp_ff * cos_rd_ff;
   assign px = xp_ff * sin_rd_ff;
   always_ff @(posedge clock) begin
      pz_ff    <= pz;
      px_ff    <= px;
      base2_ff <= base1_ff;
   end

   // stage 3: r, window test and offset from r_min
   assign psum     = pz_ff + px_ff;
   assign r_val    = psum[PW:16];
   assign rmin35   = {{3{r_min_ff[31]}}, r_min_ff};
   assign rmax35   = {{3{r_max_ff[31]}}, r_max_ff};
   assign in_range = (r_val >= rmin35) && (r_val <= rmax35);
   assign r_diff   = r_val - rmin35;
   always_ff @(posedge clock) begin
      d3_ff    <= r_diff[31:0];
      base3_ff <= base2_ff;
   end

   // stage 4: scale by the reciprocal bin width in two halves
   always_ff @(posedge clock) begin
      mh_ff    <= 48'(d3_ff * r_inv_ff[31:16]);
      ml_ff    <= 48'(d3_ff * r_inv_ff[15:0]);
      base4_ff <= base3_ff;
   end

   // stage 5: bin index with clamp to the last r bin
   assign acc     = {1'b0, mh_ff} + {17'b0, ml_ff[47:16]};
   assign idx     = acc[48:24];
   assign idx_sel = (idx > IXW'(nr_m1)) ? nr_m1[RIW-1:0] : idx[RIW-1:0];
   always_ff @(posedge clock) begin
      addr5_ff <= base4_ff + AW'(idx_sel);
      addr6_ff <= addr5_ff;
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff && in_range;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   // store read port: vote pipeline or bin read
   assign rd_ok    = ti_ok && (32'(ri_ff) < R_BINS);
   assign bin_addr = rd_ok ? AW'(32'(ti_ff) * R_BINS + 32'(ri_ff)) : '0;
   assign rd_addr  = cmd.read_bin ? bin_addr : addr5_ff;
   always_ff @(posedge clock) begin
      if (v5_ff || cmd.read_bin) rd_ff <= store[rd_addr];
   end

   // store write port: clear sweep or saturating increment
   assign inc_count = (rd_ff == chva_pkg::COUNT_MAX) ? rd_ff : rd_ff + 1'b1;
   always_ff @(posedge clock) begin
      if (cmd.clear_step) store[clear_addr_ff] <= '0;
      else if (v6_ff) store[addr6_ff] <= inc_count;
   end

   // running maximum
   always_ff @(posedge clock) begin
      if (reset || cmd.max_clear) max_count_ff <= '0;
      else if (v6_ff && (inc_count > max_count_ff)) max_count_ff <= inc_count;
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_bin_count <= (op_ff == chva_pkg::OP_READ && rd_ok) ? rd_ff : '0;
         rsp_vote_max  <= max_count_ff;
         rsp_status    <= (op_ff == chva_pkg::OP_VOTE) && status.zero_radius;
      end
   end

   // status to the controller
   always_comb begin
      status.op          = op_ff;
      status.zero_radius = (z_ff == '0) && (x_ff == '0);
      status.div_done    = done_z && done_x;
      status.theta_done  = theta_cnt_ff >= nth;
      status.clear_last  = clear_addr_ff == AW'(DEPTH - 1);
      status.pipe_empty  = !(v1_ff || v2_ff || v3_ff || v4_ff || v5_ff || v6_ff);
   end

   `CHVA_ASSERT_SAME(a_read_port_free, v5_ff, !cmd.read_bin, "bin read collides with vote read")
   `CHVA_ASSERT_SAME(a_clear_when_idle, cmd.clear_step, status.pipe_empty, "clear during votes")
   `CHVA_ASSERT_NEXT(a_max_covers, v6_ff, max_count_ff >= $past(inc_count), "max below a count")

endmodule

`default_nettype wire

### design/chva_ctrl.sv
// controller state machine of the hough vote accumulator
`default_nettype none
`include "conformal_hough_vote_accumulator_macros.svh"

module chva_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output chva_pkg::dp_cmd_type          cmd,
   input  wire chva_pkg::dp_status_type  status
);

   chva_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                clr_rsp_ff, clr_rsp_in;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chva_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         clr_rsp_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_rsp_ff   <= clr_rsp_in;
      end
   end

   // next state and commands
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      clr_rsp_in   = clr_rsp_ff;
      unique case (state_ff)
         chva_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in   = clr_rsp_ff ? chva_pkg::ST_FINISH : chva_pkg::ST_IDLE;
               clr_rsp_in = 1'b0;
            end
         end
         chva_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = chva_pkg::ST_DECODE;
            end
         end
         chva_pkg::ST_DECODE: begin
            unique case (status.op)
               chva_pkg::OP_VOTE: begin
                  state_in = status.zero_radius ? chva_pkg::ST_FINISH : chva_pkg::ST_SQUARE;
               end
               chva_pkg::OP_READ: state_in = chva_pkg::ST_READ;
               chva_pkg::OP_CLEAR: begin
                  cmd.max_clear = 1'b1;
                  clr_rsp_in    = 1'b1;
                  state_in      = chva_pkg::ST_CLEAR;
               end
               chva_pkg::OP_TRIG: begin
                  cmd.trig_write = 1'b1;
                  state_in       = chva_pkg::ST_FINISH;
               end
            endcase
         end
         chva_pkg::ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = chva_pkg::ST_SUM;
         end
         chva_pkg::ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = chva_pkg::ST_DIV_START;
         end
         chva_pkg::ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = chva_pkg::ST_DIV_WAIT;
         end
         chva_pkg::ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.theta_init = 1'b1;
               state_in       = chva_pkg::ST_VOTE;
            end
         end
         chva_pkg::ST_VOTE: begin
            if (!status.theta_done) cmd.issue = 1'b1;
            else if (status.pipe_empty) state_in = chva_pkg::ST_FINISH;
         end
         chva_pkg::ST_READ: begin
            cmd.read_bin = 1'b1;
            state_in     = chva_pkg::ST_FINISH;
         end
         chva_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = chva_pkg::ST_IDLE;
            end
         end
         default: state_in = chva_pkg::ST_IDLE;
      endcase
   end

   assign req_ready = state_ff == chva_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   `CHVA_ASSERT_NEXT(a_accept_decode, req_valid && req_ready, state_ff == chva_pkg::ST_DECODE, "transfer not decoded")
   `CHVA_ASSERT_NEXT(a_load_shows, cmd.rsp_load, rsp_valid_ff, "loaded result not shown")
   `CHVA_ASSERT_SAME(a_finish_drained, state_ff == chva_pkg::ST_FINISH, status.pipe_empty, "result before votes drained")

endmodule

`default_nettype wire
